// ===== rtl/lut_map_and_bin_average_macros.svh =====
// Assertion macros shared by the tone-map and binning RTL.
// Used by files that hold concurrent checks; expects clk and rst_n in scope.
`ifndef LUT_MAP_AND_BIN_AVERAGE_MACROS_SVH
`define LUT_MAP_AND_BIN_AVERAGE_MACROS_SVH

// same-cycle implication, checked outside reset
`define LMBA_ASSERT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lmba check failed");

// next-cycle implication, checked outside reset
`define LMBA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lmba check failed");

`endif

// ===== rtl/lmba_pkg.sv =====
// Shared types and constants for the tone-map and block-average pipeline.
// No dependencies; imported by lmba_div and lut_map_and_bin_average.
`default_nettype none

package lmba_pkg;

    // default sizing
    localparam int MAX_WIDTH_DEF     = 4096;
    localparam int MAX_BIN_SHIFT_DEF = 4;
    localparam int PIXEL_BITS_DEF    = 16;
    localparam int MAX_HEIGHT        = 4096;
    localparam int REGION_RESET      = 4096;

    // field widths
    localparam int GREY_W   = 8;
    localparam int SAMPLE_W = 16;
    localparam int REG_W    = 13;
    localparam int SHIFT_W  = 3;
    localparam int CFG_IDX_W = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_SHIFT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_HEIGHT = 2'd2;

    // item kinds
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_PIXEL = 1'b1;

    typedef struct packed {
        logic                action;
        logic [SAMPLE_W-1:0] table_index;
        logic [GREY_W-1:0]   table_value;
        logic [SAMPLE_W-1:0] pixel;
    } lmba_in_t;

    typedef struct packed {
        logic [GREY_W-1:0] grey;
        logic              last_in_row;
        logic              last_in_frame;
    } lmba_out_t;

    // divider status toward the top level
    typedef struct packed {
        logic busy;
        logic done;
    } lmba_div_stat_t;

endpackage

`default_nettype wire

// ===== rtl/lut_map_and_bin_average.sv =====
// Each accepted item is either a tone table load (written at the accept edge, no result) or
// a pixel. A pixel is mapped through the table and, with binning on, added into a running
// block sum kept in an on-chip memory of MAX_WIDTH/2 entries; a read and a write of the
// same slot can overlap and are forwarded. Loads and pixels are taken one per cycle while
// input is not stalled. A mapped pixel or full-block average passes from the calc stage into
// the output register; it waits in the calc stage while the output or the divider is busy.
// A block clipped at the right or bottom edge is divided by its true pixel count in a serial
// divider, and input stalls until that quotient has moved into the output register. After
// reset and after every write to the bin shift, region width or region height register the
// block-sum memory is cleared, one entry a cycle; input stalls during that pass, register
// writes are still taken.
// Depends on lmba_pkg, lmba_div and lut_map_and_bin_average_macros.svh.
`default_nettype none

`include "lut_map_and_bin_average_macros.svh"

module lut_map_and_bin_average
    import lmba_pkg::*;
#(
    parameter int MAX_WIDTH     = MAX_WIDTH_DEF,
    parameter int MAX_BIN_SHIFT = MAX_BIN_SHIFT_DEF,
    parameter int PIXEL_BITS    = PIXEL_BITS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire lmba_in_t             in_data,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output lmba_out_t                 out_data,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [REG_W-1:0]     cfg_data
);

    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = $clog2(MAX_HEIGHT);
    localparam int WW        = $clog2(MAX_WIDTH + 1);
    localparam int HW        = $clog2(MAX_HEIGHT + 1);
    localparam int SW        = $clog2(MAX_BIN_SHIFT + 1);
    localparam int SIDE_W    = MAX_BIN_SHIFT + 1;
    localparam int CNT_W     = 2 * MAX_BIN_SHIFT + 1;
    localparam int SUM_W     = GREY_W + 2 * MAX_BIN_SHIFT + 1;
    localparam int SUM_DEPTH = MAX_WIDTH / 2;
    localparam int SLOT_W    = $clog2(SUM_DEPTH);
    localparam int XW        = COL_W + MAX_BIN_SHIFT + 1;
    localparam int YW        = ROW_W + MAX_BIN_SHIFT + 1;
    localparam int TBL_DEPTH = 1 << PIXEL_BITS;
    localparam int W_RESET   = (MAX_WIDTH < REGION_RESET) ? MAX_WIDTH : REGION_RESET;

    // memories
    logic [GREY_W-1:0] tone_mem [TBL_DEPTH];
    logic [SUM_W-1:0]  sum_mem  [SUM_DEPTH];
    logic [GREY_W-1:0] tone_rd_reg;
    logic [SUM_W-1:0]  sum_rd_reg;

    // configuration and position
    logic [SW-1:0]    s_reg, s_next;
    logic [WW-1:0]    w_reg, w_next;
    logic [HW-1:0]    h_reg, h_next;
    logic             restart;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    // clearing pass
    logic              clr_active_reg, clr_active_next;
    logic [SLOT_W-1:0] clr_addr_reg, clr_addr_next;

    // calc stage
    logic              p1_valid_reg, p1_valid_next;
    logic [SLOT_W-1:0] p1_slot_reg;
    logic              p1_done_reg;
    logic              p1_edge_reg;
    logic [CNT_W-1:0]  p1_cnt_reg;
    logic              p1_row_end_reg;
    logic              p1_frame_end_reg;
    logic              fwd_hit_reg;
    logic [SUM_W-1:0]  fwd_data_reg;

    // output register
    logic      out_valid_reg, out_valid_next;
    lmba_out_t out_data_reg;
    logic      div_row_end_reg;
    logic      div_frame_end_reg;

    // position-derived values for the next pixel
    logic [XW-1:0]       col_x, w_x, side_x, mask_x, xs_x;
    logic [YW-1:0]       row_y, h_y, side_y, mask_y, ys_y;
    logic                row_end, last_row, frame_end;
    logic                x_done, y_done, short_x, short_y;
    logic [SIDE_W-1:0]   nx, ny;
    logic [2*SIDE_W-1:0] prod;
    logic                done_now;
    logic [COL_W-1:0]    slot_raw;
    logic [SLOT_W-1:0]   slot_now;

    // handshake and calc
    logic              in_acc, pix_acc, load_acc;
    logic              bin_on, out_free, div_active, is_div, calc_go;
    logic              calc_out, div_start, div_take, out_load;
    logic [SUM_W-1:0]  prev_sum, total, avg;
    logic [GREY_W-1:0] calc_grey;
    logic              sum_we;
    logic [SLOT_W-1:0] sum_wa;
    logic [SUM_W-1:0]  sum_wd;

    lmba_div_stat_t    div_stat;
    logic [SUM_W-1:0]  div_quo;

    // register writes, clamped to the supported ranges
    always_comb
    begin
        int unsigned v;
        v       = 32'(cfg_data);
        s_next  = s_reg;
        w_next  = w_reg;
        h_next  = h_reg;
        restart = 1'b0;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BIN_SHIFT:
                begin
                    s_next  = (cfg_data[SHIFT_W-1:0] > MAX_BIN_SHIFT) ?
                              SW'(MAX_BIN_SHIFT) : SW'(cfg_data[SHIFT_W-1:0]);
                    restart = 1'b1;
                end
                CFG_REGION_WIDTH:
                begin
                    w_next  = (v == 0) ? WW'(1) : ((v > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(v));
                    restart = 1'b1;
                end
                CFG_REGION_HEIGHT:
                begin
                    h_next  = (v == 0) ? HW'(1) :
                              ((v > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(v));
                    restart = 1'b1;
                end
                default:
                begin
                    restart = 1'b0;
                end
            endcase
        end
    end

    // block geometry at the current position
    always_comb
    begin
        col_x     = XW'(col_reg);
        w_x       = XW'(w_reg);
        side_x    = XW'(1) << s_reg;
        mask_x    = side_x - XW'(1);
        row_y     = YW'(row_reg);
        h_y       = YW'(h_reg);
        side_y    = YW'(1) << s_reg;
        mask_y    = side_y - YW'(1);
        row_end   = (col_x + XW'(1)) >= w_x;
        last_row  = (row_y + YW'(1)) >= h_y;
        frame_end = row_end && last_row;
        x_done    = ((col_x & mask_x) == mask_x) || row_end;
        y_done    = ((row_y & mask_y) == mask_y) || last_row;
        xs_x      = col_x & ~mask_x;
        ys_y      = row_y & ~mask_y;
        short_x   = (xs_x + side_x) > w_x;
        short_y   = (ys_y + side_y) > h_y;
        nx        = short_x ? SIDE_W'(w_x - xs_x) : SIDE_W'(side_x);
        ny        = short_y ? SIDE_W'(h_y - ys_y) : SIDE_W'(side_y);
        prod      = nx * ny;
        done_now  = (s_reg == '0) || (x_done && y_done);
        // slot wraps once past the memory depth
        slot_raw  = col_reg >> s_reg;
        if (slot_raw >= SUM_DEPTH)
        begin
            slot_now = SLOT_W'(slot_raw - COL_W'(SUM_DEPTH));
        end
        else
        begin
            slot_now = slot_raw[SLOT_W-1:0];
        end
    end

    // calc stage: accumulate, decide where the result goes
    always_comb
    begin
        bin_on     = (s_reg != '0);
        out_free   = !out_valid_reg || !out_stall;
        div_active = div_stat.busy || div_stat.done;
        is_div     = p1_done_reg && bin_on && p1_edge_reg;
        calc_go    = p1_valid_reg && (!p1_done_reg || (!div_active && (is_div || out_free)));
        prev_sum   = fwd_hit_reg ? fwd_data_reg : sum_rd_reg;
        total      = prev_sum + SUM_W'(tone_rd_reg);
        avg        = total >> {s_reg, 1'b0};
        calc_grey  = bin_on ? avg[GREY_W-1:0] : tone_rd_reg;
        calc_out   = calc_go && p1_done_reg && !is_div;
        div_start  = calc_go && is_div;
        div_take   = div_stat.done && out_free;
        out_load   = calc_out || div_take;
    end

    // input handshake
    assign in_stall = clr_active_reg || div_active || (p1_valid_reg && !calc_go);
    assign in_acc   = in_valid && !in_stall;
    assign pix_acc  = in_acc && (in_data.action == ACT_PIXEL);
    assign load_acc = in_acc && (in_data.action == ACT_LOAD);

    // block-sum write port: clearing pass or calc write-back
    always_comb
    begin
        if (clr_active_reg)
        begin
            sum_we = 1'b1;
            sum_wa = clr_addr_reg;
            sum_wd = '0;
        end
        else
        begin
            sum_we = calc_go && bin_on;
            sum_wa = p1_slot_reg;
            sum_wd = p1_done_reg ? '0 : total;
        end
    end

    // tone table
    always_ff @(posedge clk)
    begin
        if (load_acc)
        begin
            tone_mem[in_data.table_index[PIXEL_BITS-1:0]] <= in_data.table_value;
        end
        if (pix_acc)
        begin
            tone_rd_reg <= tone_mem[in_data.pixel[PIXEL_BITS-1:0]];
        end
    end

    // block sums
    always_ff @(posedge clk)
    begin
        if (sum_we)
        begin
            sum_mem[sum_wa] <= sum_wd;
        end
        if (pix_acc)
        begin
            sum_rd_reg <= sum_mem[slot_now];
        end
    end

    // next control state
    always_comb
    begin
        col_next        = col_reg;
        row_next        = row_reg;
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (restart)
        begin
            col_next        = '0;
            row_next        = '0;
            clr_active_next = 1'b1;
            clr_addr_next   = '0;
        end
        else
        begin
            if (clr_active_reg)
            begin
                clr_addr_next = clr_addr_reg + SLOT_W'(1);
                if (clr_addr_reg == SLOT_W'(SUM_DEPTH - 1))
                begin
                    clr_active_next = 1'b0;
                end
            end
            if (pix_acc)
            begin
                priority if (frame_end)
                begin
                    col_next = '0;
                    row_next = '0;
                end
                else if (row_end)
                begin
                    col_next = '0;
                    row_next = row_reg + ROW_W'(1);
                end
                else
                begin
                    col_next = col_reg + COL_W'(1);
                end
            end
        end
        p1_valid_next = pix_acc ? 1'b1 : (calc_go ? 1'b0 : p1_valid_reg);
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_reg          <= '0;
            w_reg          <= WW'(W_RESET);
            h_reg          <= HW'(REGION_RESET);
            col_reg        <= '0;
            row_reg        <= '0;
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            p1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            s_reg          <= s_next;
            w_reg          <= w_next;
            h_reg          <= h_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
            p1_valid_reg   <= p1_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // calc stage payload and same-slot forwarding
    always_ff @(posedge clk)
    begin
        if (pix_acc)
        begin
            p1_slot_reg      <= slot_now;
            p1_done_reg      <= done_now;
            p1_edge_reg      <= short_x || short_y;
            p1_cnt_reg       <= CNT_W'(prod);
            p1_row_end_reg   <= row_end;
            p1_frame_end_reg <= frame_end;
            fwd_hit_reg      <= calc_go && bin_on && (p1_slot_reg == slot_now);
            fwd_data_reg     <= p1_done_reg ? '0 : total;
        end
        if (div_start)
        begin
            div_row_end_reg   <= p1_row_end_reg;
            div_frame_end_reg <= p1_frame_end_reg;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (div_take)
        begin
            out_data_reg.grey          <= div_quo[GREY_W-1:0];
            out_data_reg.last_in_row   <= div_row_end_reg;
            out_data_reg.last_in_frame <= div_frame_end_reg;
        end
        else if (calc_out)
        begin
            out_data_reg.grey          <= calc_grey;
            out_data_reg.last_in_row   <= p1_row_end_reg;
            out_data_reg.last_in_frame <= p1_frame_end_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // edge-block divider
    lmba_div #(
        .NUM_W (SUM_W),
        .DEN_W (CNT_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (total),
        .den   (p1_cnt_reg),
        .take  (div_take),
        .stat  (div_stat),
        .quo   (div_quo)
    );

    // checks
    `LMBA_ASSERT(a_clear_blocks_input, clr_active_reg, in_stall)
    `LMBA_ASSERT(a_div_start_idle, div_start, !div_active)
    `LMBA_ASSERT(a_out_load_free, out_load, !out_valid_reg || !out_stall)
    `LMBA_ASSERT(a_pos_in_region, 1'b1, (WW'(col_reg) < w_reg) && (HW'(row_reg) < h_reg))
    `LMBA_ASSERT_NEXT(a_div_runs, div_start, div_stat.busy)

endmodule

`default_nettype wire

// ===== rtl/lmba_div.sv =====
// Serial restoring divider for edge-block averages, one quotient bit per cycle.
// Depends on lmba_pkg for the status struct.
`default_nettype none

module lmba_div
    import lmba_pkg::*;
#(
    parameter int NUM_W = 17,
    parameter int DEN_W = 9
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    input  wire logic             take,
    output lmba_div_stat_t        stat,
    output logic [NUM_W-1:0]      quo
);

    localparam int CNT_BITS = $clog2(NUM_W);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0]    num_reg, num_next;
    logic [DEN_W-1:0]    rem_reg, rem_next;
    logic [DEN_W-1:0]    den_reg;
    logic [DEN_W:0]      trial;
    logic                ge;

    // one restoring step: shift in the next numerator bit, subtract if it fits
    always_comb
    begin
        trial     = {rem_reg, num_reg[NUM_W-1]};
        ge        = (trial >= {1'b0, den_reg});
        rem_next  = ge ? DEN_W'(trial - {1'b0, den_reg}) : DEN_W'(trial);
        num_next  = {num_reg[NUM_W-2:0], ge};
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            cnt_next  = CNT_BITS'(NUM_W - 1);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - CNT_BITS'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (take)
        begin
            done_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quo       = num_reg;

endmodule

`default_nettype wire

// ===== bench/lut_map_and_bin_average_tb.sv =====
// Self-checking bench for lut_map_and_bin_average: table loads, mapping and block averaging.
// Carries its own image model and compares every output transfer against it.
// Depends on lmba_pkg and the lut_map_and_bin_average RTL.
module lut_map_and_bin_average_tb;
    import lmba_pkg::*;

    localparam int CYCLE_LIMIT     = 5_000_000;
    localparam int SETTLE_CYCLES   = 40;
    localparam int SUM_SLOTS       = MAX_WIDTH_DEF / 2;
    localparam int RANDOM_ITEMS    = 1540;
    localparam int SATURATED_ITEMS = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    lmba_in_t             in_data   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    lmba_out_t            out_data;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [REG_W-1:0]     cfg_data  = '0;

    // image model state
    logic [GREY_W-1:0]    tone_copy [0:65535];
    bit                   tone_loaded [0:65535];
    logic [SAMPLE_W-1:0]  loaded_codes [$];
    int unsigned          block_sum_copy [0:SUM_SLOTS-1];
    int unsigned          col_pos = 0;
    int unsigned          row_pos = 0;
    logic [SHIFT_W-1:0]   shift_copy  = '0;
    logic [REG_W-1:0]     width_copy  = REG_W'(REGION_RESET);
    logic [REG_W-1:0]     height_copy = REG_W'(REGION_RESET);
    lmba_out_t            grey_expected [$];

    // knobs and bookkeeping
    bit                   gaps_on      = 1'b1;
    bit                   stall_enable = 1'b1;
    int unsigned          stall_hold   = 0;
    int unsigned          cycle_count  = 0;
    int unsigned          mismatch_count = 0;
    int unsigned          loads_sent   = 0;
    int unsigned          pixels_sent  = 0;
    int unsigned          results_seen = 0;
    int unsigned          settings_used = 0;

    lut_map_and_bin_average dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("lut_map_and_bin_average_tb NOT OK");
            $finish;
        end
    end

    // mostly short idle lengths, a few long ones
    function automatic int unsigned pick_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // receiver stall pattern
    always @(posedge clk)
    begin
        if (stall_hold != 0)
            stall_hold <= stall_hold - 1;
        else if (!stall_enable)
            out_stall <= 1'b0;
        else
        begin
            out_stall  <= ($urandom_range(0, 2) == 0);
            stall_hold <= pick_length();
        end
    end

    // compare each output transfer with the oldest expected result
    always @(posedge clk)
    begin
        lmba_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen <= results_seen + 1;
            if (grey_expected.size() == 0)
            begin
                $error("unexpected output transfer: grey %0d row %0b frame %0b",
                       out_data.grey, out_data.last_in_row, out_data.last_in_frame);
                mismatch_count++;
            end
            else
            begin
                want = grey_expected.pop_front();
                if (out_data.grey !== want.grey)
                begin
                    $error("grey: expected %0d, actual %0d", want.grey, out_data.grey);
                    mismatch_count++;
                end
                if (out_data.last_in_row !== want.last_in_row)
                begin
                    $error("last_in_row: expected %0b, actual %0b",
                           want.last_in_row, out_data.last_in_row);
                    mismatch_count++;
                end
                if (out_data.last_in_frame !== want.last_in_frame)
                begin
                    $error("last_in_frame: expected %0b, actual %0b",
                           want.last_in_frame, out_data.last_in_frame);
                    mismatch_count++;
                end
            end
        end
    end

    function automatic int unsigned effective_size(input logic [REG_W-1:0] v,
                                                   input int unsigned cap);
        if (v == 0)
            return 1;
        return (v > cap) ? cap : 32'(v);
    endfunction

    // any listed register write restarts the frame, table kept
    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [REG_W-1:0] data);
        if (idx == CFG_BIN_SHIFT)
            shift_copy = data[SHIFT_W-1:0];
        else if (idx == CFG_REGION_WIDTH)
            width_copy = data;
        else if (idx == CFG_REGION_HEIGHT)
            height_copy = data;
        else
            return;
        col_pos = 0;
        row_pos = 0;
        foreach (block_sum_copy[i])
            block_sum_copy[i] = 0;
    endfunction

    // image model: one accepted item, zero or one expected result
    function automatic void predict_grey(input lmba_in_t item);
        int unsigned w, h, s, side, slot, mapped, x0, y0, nx, ny, avg;
        bit          row_end, frame_end, x_done, y_done, emit;
        lmba_out_t   res;
        if (item.action == ACT_LOAD)
        begin
            tone_copy[item.table_index] = item.table_value;
            if (!tone_loaded[item.table_index])
            begin
                tone_loaded[item.table_index] = 1'b1;
                loaded_codes.push_back(item.table_index);
            end
            return;
        end
        w         = effective_size(width_copy, MAX_WIDTH_DEF);
        h         = effective_size(height_copy, MAX_HEIGHT);
        s         = (shift_copy > MAX_BIN_SHIFT_DEF) ? MAX_BIN_SHIFT_DEF : 32'(shift_copy);
        mapped    = 32'(tone_copy[item.pixel]);
        row_end   = (col_pos + 1 >= w);
        frame_end = row_end && (row_pos + 1 >= h);
        emit      = 1'b0;
        res       = '0;
        if (s == 0)
        begin
            res.grey = mapped[GREY_W-1:0];
            emit     = 1'b1;
        end
        else
        begin
            side = 1 << s;
            slot = (col_pos >> s) % SUM_SLOTS;
            block_sum_copy[slot] += mapped;
            x_done = ((col_pos & (side - 1)) == side - 1) || row_end;
            y_done = ((row_pos & (side - 1)) == side - 1) || (row_pos + 1 >= h);
            if (x_done && y_done)
            begin
                x0 = col_pos & ~(side - 1);
                y0 = row_pos & ~(side - 1);
                nx = (x0 + side > w) ? w - x0 : side;
                ny = (y0 + side > h) ? h - y0 : side;
                // clipped blocks divide by the true pixel count
                if (nx != side || ny != side)
                    avg = block_sum_copy[slot] / (nx * ny);
                else
                    avg = block_sum_copy[slot] >> (2 * s);
                block_sum_copy[slot] = 0;
                res.grey = avg[GREY_W-1:0];
                emit     = 1'b1;
            end
        end
        if (emit)
        begin
            res.last_in_row   = row_end;
            res.last_in_frame = frame_end;
            grey_expected.push_back(res);
        end
        if (frame_end)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        else if (row_end)
        begin
            col_pos = 0;
            row_pos = row_pos + 1;
        end
        else
            col_pos = col_pos + 1;
    endfunction

    function automatic lmba_in_t load_item(input logic [SAMPLE_W-1:0] idx,
                                           input logic [GREY_W-1:0] val);
        lmba_in_t it;
        it.action      = ACT_LOAD;
        it.table_index = idx;
        it.table_value = val;
        it.pixel       = SAMPLE_W'($urandom);
        return it;
    endfunction

    function automatic lmba_in_t pixel_item(input logic [SAMPLE_W-1:0] code);
        lmba_in_t it;
        it.action      = ACT_PIXEL;
        it.table_index = SAMPLE_W'($urandom);
        it.table_value = GREY_W'($urandom);
        it.pixel       = code;
        return it;
    endfunction

    // only codes whose table entry was loaded
    function automatic logic [SAMPLE_W-1:0] pick_code();
        return loaded_codes[$urandom_range(0, loaded_codes.size() - 1)];
    endfunction

    // one input transfer, then an optional gap
    task automatic send_item(input lmba_in_t item);
        int unsigned gap;
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_grey(item);
        if (item.action == ACT_LOAD)
            loads_sent++;
        else
            pixels_sent++;
        gap = gaps_on ? pick_length() : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // sender holds off until every expected result has arrived
    task automatic hold_until_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (grey_expected.size() != 0)
            @(posedge clk);
    endtask

    // drained plus time for a divide still in flight
    task automatic settle_after_results();
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [REG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        apply_register(idx, data);
        @(posedge clk);
    endtask

    task automatic configure_region(input logic [SHIFT_W-1:0] shift,
                                    input logic [REG_W-1:0] width,
                                    input logic [REG_W-1:0] height);
        logic [REG_W-1:0] shift_word;
        settle_after_results();
        shift_word = REG_W'($urandom);
        shift_word[SHIFT_W-1:0] = shift;
        write_register(CFG_BIN_SHIFT, shift_word);
        write_register(CFG_REGION_WIDTH, width);
        write_register(CFG_REGION_HEIGHT, height);
        settings_used++;
    endtask

    // reset registers, table extremes and an overwritten entry
    task automatic test_reset_defaults_and_table();
        gaps_on      = 1'b1;
        stall_enable = 1'b1;
        send_item(load_item(16'h0000, 8'hFF));
        send_item(load_item(16'hFFFF, 8'h00));
        send_item(load_item(16'h8000, 8'hA5));
        send_item(load_item(16'h7FFF, 8'h5A));
        send_item(load_item(16'h5555, 8'h80));
        send_item(load_item(16'hAAAA, 8'h7F));
        send_item(pixel_item(16'h0000));
        send_item(pixel_item(16'hFFFF));
        send_item(pixel_item(16'h8000));
        send_item(pixel_item(16'h7FFF));
        send_item(pixel_item(16'h5555));
        send_item(pixel_item(16'hAAAA));
        send_item(load_item(16'h0000, 8'h01));
        send_item(pixel_item(16'h0000));
    endtask

    // zero sizes act as a 1x1 region
    task automatic test_zero_size_region();
        configure_region(3'd0, 13'd0, 13'd0);
        send_item(pixel_item(16'hFFFF));
        send_item(pixel_item(16'h0000));
    endtask

    // 3x3 region in 2x2 blocks: full, right-clipped, bottom-clipped, corner;
    // a write to the spare index mid-frame must not restart it
    task automatic test_clipped_blocks();
        configure_region(3'd1, 13'd3, 13'd3);
        send_item(pixel_item(16'h0000));
        send_item(pixel_item(16'h8000));
        send_item(pixel_item(16'h7FFF));
        send_item(pixel_item(16'hAAAA));
        settle_after_results();
        write_register(CFG_SPARE, REG_W'($urandom));
        send_item(pixel_item(16'h0000));
        send_item(pixel_item(16'h5555));
        send_item(pixel_item(16'h8000));
        send_item(pixel_item(16'h0000));
        send_item(pixel_item(16'h7FFF));
    endtask

    // whole frames with random content, loads mixed in, some frames cut short
    task automatic test_random_frames();
        int unsigned      budget_start, npix, frames;
        logic [SHIFT_W-1:0] shift;
        logic [REG_W-1:0] width, height;
        bit               cut;
        budget_start = loads_sent + pixels_sent;
        repeat (32)
            send_item(load_item(SAMPLE_W'($urandom), GREY_W'($urandom)));
        while (loads_sent + pixels_sent - budget_start < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 3) == 0)
                shift = SHIFT_W'($urandom_range(5, 7));
            else
                shift = SHIFT_W'($urandom_range(0, 4));
            if ($urandom_range(0, 15) == 0)
                width = '0;
            else if ($urandom_range(0, 7) == 0)
                width = REG_W'($urandom_range(25, 64));
            else
                width = REG_W'($urandom_range(1, 24));
            if ($urandom_range(0, 15) == 0)
                height = '0;
            else if ($urandom_range(0, 7) == 0)
                height = REG_W'($urandom_range(13, 20));
            else
                height = REG_W'($urandom_range(1, 12));
            configure_region(shift, width, height);
            gaps_on      = ($urandom_range(0, 3) != 0);
            stall_enable = ($urandom_range(0, 3) != 0);
            frames = $urandom_range(1, 3);
            cut    = 1'b0;
            for (int f = 0; f < frames && !cut &&
                 loads_sent + pixels_sent - budget_start < RANDOM_ITEMS; f++)
            begin
                npix = effective_size(width, MAX_WIDTH_DEF) * effective_size(height, MAX_HEIGHT);
                if ($urandom_range(0, 7) == 0)
                begin
                    npix = $urandom_range(0, npix - 1);
                    cut  = 1'b1;
                end
                for (int p = 0; p < npix &&
                     loads_sent + pixels_sent - budget_start < RANDOM_ITEMS; p++)
                begin
                    if ($urandom_range(0, 9) == 0)
                        send_item(load_item(SAMPLE_W'($urandom), GREY_W'($urandom)));
                    send_item(pixel_item(pick_code()));
                    if (f == 0 && p == npix / 2)
                        hold_until_drained();
                end
            end
        end
    endtask

    // oversize width and two-wide blocks: the first columns of a long row
    task automatic test_saturated_width();
        configure_region(3'd1, 13'd8191, 13'd1);
        gaps_on      = 1'b1;
        stall_enable = 1'b1;
        repeat (SATURATED_ITEMS)
            send_item(pixel_item(pick_code()));
    endtask

    // oversize height and shift; 1-wide column blocks go through the divider
    task automatic test_saturated_height();
        configure_region(3'd7, 13'd1, 13'd8191);
        repeat (SATURATED_ITEMS)
            send_item(pixel_item(pick_code()));
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_defaults_and_table();
        test_zero_size_region();
        test_clipped_blocks();
        test_random_frames();
        test_saturated_width();
        test_saturated_height();
        settle_after_results();
        $display("ran %0d table loads and %0d pixels over %0d region settings",
                 loads_sent, pixels_sent, settings_used);
        $display("checked %0d results, shifts 0..7, sizes 0..8191, clipped and full blocks",
                 results_seen);
        if (mismatch_count == 0)
            $display("lut_map_and_bin_average_tb OK");
        else
            $display("lut_map_and_bin_average_tb NOT OK");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/lmba_pkg.sv
rtl/lmba_div.sv
rtl/lut_map_and_bin_average.sv
bench/lut_map_and_bin_average_tb.sv
